[rtl/sobm_pkg.sv]
// Shared types, constants and kernel helpers for the RGB Sobel magnitude block.
`timescale 1ns / 1ps
package sobm_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int RING_ROWS    = 3;
    localparam int RAM_DEPTH    = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_W       = $clog2(RAM_DEPTH);
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int HEIGHT_LIMIT = 4096;
    localparam int WCFG_W       = 11;
    localparam int HCFG_W       = 13;
    localparam int OROW_W       = $clog2(HEIGHT_LIMIT);
    localparam int POS_W        = 22;
    localparam int GRAD_W       = 12;
    localparam int SUM_W        = 21;
    localparam int ROOT_BITS    = 8;
    localparam int ROOT_CNT_W   = 4;
    localparam int CAP_SUM      = 65280;

    typedef logic [23:0] pixel_t;
    typedef logic [1:0]  ring_t;
    typedef logic [1:0]  tap_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROOT,
        ST_DONE
    } state_t;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    function automatic logic [ADDR_W-1:0] ring_addr(input ring_t ring,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

    function automatic logic signed [2:0] kern_x(input tap_t k, input tap_t l);
        logic signed [2:0] m;
        logic signed [2:0] r;
        m = (k == 2'd1) ? 3'sd2 : 3'sd1;
        case (l)
            2'd0:    r = -m;
            2'd2:    r = m;
            default: r = 3'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [2:0] kern_y(input tap_t k, input tap_t l);
        logic signed [2:0] m;
        logic signed [2:0] r;
        m = (l == 2'd1) ? 3'sd2 : 3'sd1;
        case (k)
            2'd0:    r = -m;
            2'd2:    r = m;
            default: r = 3'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [GRAD_W-1:0] tap_term(input logic [7:0] v,
                                                          input logic signed [2:0] wt);
        logic signed [GRAD_W-1:0] sv;
        logic signed [GRAD_W-1:0] r;
        sv = $signed({{(GRAD_W-8){1'b0}}, v});
        case (wt)
            3'b001:  r = sv;
            3'b111:  r = -sv;
            3'b010:  r = sv <<< 1;
            3'b110:  r = -(sv <<< 1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/sobm_ifs.sv]
// Valid/ready channel interfaces for pixels, results and configuration.
`timescale 1ns / 1ps
interface sobm_pix_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    modport source (output valid, kind, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface sobm_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface sobm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic                         index;
    logic [sobm_pkg::HCFG_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/sobel_edge_magnitude_rgb.sv]
// Streaming 3x3 Sobel gradient magnitude on RGB pixels, top level.
// Sequence: an emitting word is fetched (9 ring reads, then a read drain), then the
// root is started and computed bit by bit, and the result is loaded to the output.
// Throughput: one word a cycle while nothing is emitted; an emitting word holds
// the input until its result is loaded, longer while an unread result blocks the load.
// Reset: counters clear, width 640, height 480; ring memory is not cleared.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb (
    input  logic              clk,
    input  logic              rst_n,
    sobm_cfg_if.sink          cfg,
    sobm_pix_if.sink          pixels,
    sobm_res_if.source        results
);
    localparam int COL_W  = sobm_pkg::COL_W;
    localparam int ADDR_W = sobm_pkg::ADDR_W;
    localparam int GRAD_W = sobm_pkg::GRAD_W;

    sobm_pkg::state_t state_reg, state_next;

    logic [sobm_pkg::WCFG_W-1:0] w_reg;
    logic [sobm_pkg::HCFG_W-1:0] h_reg;
    logic [COL_W-1:0]            icol_reg;
    logic [sobm_pkg::HCFG_W-1:0] irow_reg;
    sobm_pkg::ring_t             iring_reg;
    logic [sobm_pkg::POS_W-1:0]  opos_reg;
    logic [COL_W-1:0]            ocol_reg;
    logic [sobm_pkg::OROW_W-1:0] orow_reg;
    sobm_pkg::ring_t             oring_reg;

    logic                        up_ok_reg, dn_ok_reg, lf_ok_reg, rt_ok_reg;
    sobm_pkg::ring_t             rup_reg, rmid_reg, rdn_reg;
    logic [COL_W-1:0]            bcol_reg;
    logic                        fe_reg;
    logic                        has_in_reg;
    sobm_pkg::pixel_t            pix_reg;
    logic [ADDR_W-1:0]           waddr_reg;

    logic [3:0]                  tap_reg;
    sobm_pkg::tap_t              k_reg, l_reg;
    logic                        rdv_reg, tok_reg, byp_reg;
    sobm_pkg::tap_t              kd_reg, ld_reg;
    logic signed [GRAD_W-1:0]    gx_reg [3];
    logic signed [GRAD_W-1:0]    gy_reg [3];

    logic [7:0]                  res_reg [3];
    logic                        res_fe_reg;
    logic                        ov_reg;
    logic [7:0]                  ored_reg, ogrn_reg, oblu_reg;
    logic                        ofe_reg;

    logic                        in_fire, cfg_fire, out_take;
    logic                        all_in, is_pix, emit_q, do_write, do_emit;
    logic [sobm_pkg::POS_W-1:0]  total_m1;
    logic                        issue, fetch_end, load_out, mag_done;
    logic                        ram_we, ram_re;
    logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
    sobm_pkg::pixel_t            ram_wdata, ram_q, in_pix, tap_pix;
    sobm_pkg::ring_t             tap_ring;
    logic [COL_W-1:0]            tap_col;
    logic                        tap_ok;
    logic [2:0]                  done_v;
    logic [7:0]                  mag_v [3];
    logic [sobm_pkg::WCFG_W-1:0] cfg_w;
    logic [sobm_pkg::HCFG_W-1:0] cfg_h;

    assign in_pix   = {pixels.in_red, pixels.in_green, pixels.in_blue};
    assign cfg.ready = 1'b1;
    assign cfg_fire = cfg.valid;
    assign in_fire  = pixels.valid && pixels.ready;
    assign out_take = ov_reg && results.ready;

    assign total_m1 = sobm_pkg::POS_W'(w_reg) * sobm_pkg::POS_W'(h_reg) -
                      sobm_pkg::POS_W'(1);
    assign all_in   = (irow_reg >= h_reg);
    assign is_pix   = (pixels.kind == sobm_pkg::KIND_PIXEL);
    assign emit_q   = (irow_reg >= sobm_pkg::HCFG_W'(2)) ||
                      ((irow_reg == sobm_pkg::HCFG_W'(1)) && (icol_reg != '0));
    assign do_write = is_pix && !all_in;
    assign do_emit  = (do_write && emit_q) || (all_in && (opos_reg <= total_m1));

    assign fetch_end = (tap_reg == 4'd9) && !rdv_reg;
    assign load_out  = !ov_reg || results.ready;
    assign mag_done  = &done_v;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sobm_pkg::ST_IDLE:
            begin
                if (in_fire && do_emit)
                begin
                    state_next = sobm_pkg::ST_FETCH;
                end
            end
            sobm_pkg::ST_FETCH:
            begin
                if (fetch_end)
                begin
                    state_next = sobm_pkg::ST_ROOT;
                end
            end
            sobm_pkg::ST_ROOT:
            begin
                if (mag_done)
                begin
                    state_next = sobm_pkg::ST_DONE;
                end
            end
            sobm_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = sobm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sobm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pixels.ready = 1'b0;
        issue        = 1'b0;
        case (state_reg)
            sobm_pkg::ST_IDLE:  pixels.ready = 1'b1;
            sobm_pkg::ST_FETCH: issue = (tap_reg != 4'd9);
            default:            issue = 1'b0;
        endcase
    end

    always_comb
    begin
        case (k_reg)
            2'd0:    tap_ring = rup_reg;
            2'd2:    tap_ring = rdn_reg;
            default: tap_ring = rmid_reg;
        endcase
    end
    assign tap_col = bcol_reg + COL_W'(l_reg) - COL_W'(1);
    assign tap_ok  = (k_reg != 2'd0 || up_ok_reg) && (k_reg != 2'd2 || dn_ok_reg) &&
                     (l_reg != 2'd0 || lf_ok_reg) && (l_reg != 2'd2 || rt_ok_reg);

    assign ram_re    = issue;
    assign ram_raddr = sobm_pkg::ring_addr(tap_ring, tap_col);
    always_comb
    begin
        if (state_reg == sobm_pkg::ST_FETCH)
        begin
            ram_we    = fetch_end && has_in_reg;
            ram_waddr = waddr_reg;
            ram_wdata = pix_reg;
        end
        else
        begin
            ram_we    = in_fire && do_write && !emit_q;
            ram_waddr = sobm_pkg::ring_addr(iring_reg, icol_reg);
            ram_wdata = in_pix;
        end
    end

    sobm_ring_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign tap_pix = !tok_reg ? '0 : (byp_reg ? pix_reg : ram_q);

    genvar ch;
    generate
        for (ch = 0; ch < 3; ch++)
        begin : g_mag
            sobm_mag u_mag (
                .clk   (clk),
                .rst_n (rst_n),
                .start (fetch_end && (state_reg == sobm_pkg::ST_FETCH)),
                .gx    (gx_reg[ch]),
                .gy    (gy_reg[ch]),
                .done  (done_v[ch]),
                .mag   (mag_v[ch])
            );
        end
    endgenerate

    always_comb
    begin
        cfg_w = cfg.data[sobm_pkg::WCFG_W-1:0];
        if (cfg_w == '0)
        begin
            cfg_w = sobm_pkg::WCFG_W'(1);
        end
        else if (cfg_w > sobm_pkg::WCFG_W'(sobm_pkg::MAX_WIDTH))
        begin
            cfg_w = sobm_pkg::WCFG_W'(sobm_pkg::MAX_WIDTH);
        end
        cfg_h = cfg.data;
        if (cfg_h == '0)
        begin
            cfg_h = sobm_pkg::HCFG_W'(1);
        end
        else if (cfg_h > sobm_pkg::HCFG_W'(sobm_pkg::HEIGHT_LIMIT))
        begin
            cfg_h = sobm_pkg::HCFG_W'(sobm_pkg::HEIGHT_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sobm_pkg::ST_IDLE;
            w_reg     <= sobm_pkg::WCFG_W'(640);
            h_reg     <= sobm_pkg::HCFG_W'(480);
            icol_reg  <= '0;
            irow_reg  <= '0;
            iring_reg <= '0;
            opos_reg  <= '0;
            ocol_reg  <= '0;
            orow_reg  <= '0;
            oring_reg <= '0;
            tap_reg   <= '0;
            rdv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= issue;
            if (cfg_fire)
            begin
                if (cfg.index == sobm_pkg::REG_WIDTH)
                begin
                    w_reg <= cfg_w;
                end
                else
                begin
                    h_reg <= cfg_h;
                end
                icol_reg  <= '0;
                irow_reg  <= '0;
                iring_reg <= '0;
                opos_reg  <= '0;
                ocol_reg  <= '0;
                orow_reg  <= '0;
                oring_reg <= '0;
            end
            else if (in_fire)
            begin
                if (do_write)
                begin
                    if ({1'b0, icol_reg} + sobm_pkg::WCFG_W'(1) == w_reg)
                    begin
                        icol_reg  <= '0;
                        irow_reg  <= irow_reg + sobm_pkg::HCFG_W'(1);
                        iring_reg <= (iring_reg == 2'd2) ? 2'd0 : iring_reg + 2'd1;
                    end
                    else
                    begin
                        icol_reg <= icol_reg + COL_W'(1);
                    end
                end
                if (do_emit)
                begin
                    if (opos_reg == total_m1)
                    begin
                        icol_reg  <= '0;
                        irow_reg  <= '0;
                        iring_reg <= '0;
                        opos_reg  <= '0;
                        ocol_reg  <= '0;
                        orow_reg  <= '0;
                        oring_reg <= '0;
                    end
                    else
                    begin
                        opos_reg <= opos_reg + sobm_pkg::POS_W'(1);
                        if ({1'b0, ocol_reg} + sobm_pkg::WCFG_W'(1) == w_reg)
                        begin
                            ocol_reg  <= '0;
                            orow_reg  <= orow_reg + sobm_pkg::OROW_W'(1);
                            oring_reg <= (oring_reg == 2'd2) ? 2'd0 : oring_reg + 2'd1;
                        end
                        else
                        begin
                            ocol_reg <= ocol_reg + COL_W'(1);
                        end
                    end
                end
            end
            if (in_fire && do_emit)
            begin
                tap_reg <= '0;
            end
            else if (issue)
            begin
                tap_reg <= tap_reg + 4'd1;
            end
            if (load_out && state_reg == sobm_pkg::ST_DONE)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_take)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && do_emit)
        begin
            up_ok_reg  <= (orow_reg != '0);
            dn_ok_reg  <= ({1'b0, orow_reg} + sobm_pkg::HCFG_W'(1) < h_reg);
            lf_ok_reg  <= (ocol_reg != '0);
            rt_ok_reg  <= ({1'b0, ocol_reg} + sobm_pkg::WCFG_W'(1) < w_reg);
            rmid_reg   <= oring_reg;
            rup_reg    <= (oring_reg == 2'd0) ? 2'd2 : oring_reg - 2'd1;
            rdn_reg    <= (oring_reg == 2'd2) ? 2'd0 : oring_reg + 2'd1;
            bcol_reg   <= ocol_reg;
            fe_reg     <= (opos_reg == total_m1);
            has_in_reg <= do_write;
            pix_reg    <= in_pix;
            waddr_reg  <= sobm_pkg::ring_addr(iring_reg, icol_reg);
            k_reg      <= '0;
            l_reg      <= '0;
            for (int c = 0; c < 3; c++)
            begin
                gx_reg[c] <= '0;
                gy_reg[c] <= '0;
            end
        end
        else
        begin
            if (issue)
            begin
                if (l_reg == 2'd2)
                begin
                    l_reg <= '0;
                    k_reg <= k_reg + 2'd1;
                end
                else
                begin
                    l_reg <= l_reg + 2'd1;
                end
            end
            if (rdv_reg)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    gx_reg[c] <= gx_reg[c] + sobm_pkg::tap_term(tap_pix[16-8*c +: 8],
                                 sobm_pkg::kern_x(kd_reg, ld_reg));
                    gy_reg[c] <= gy_reg[c] + sobm_pkg::tap_term(tap_pix[16-8*c +: 8],
                                 sobm_pkg::kern_y(kd_reg, ld_reg));
                end
            end
        end
        tok_reg <= tap_ok;
        byp_reg <= has_in_reg && (k_reg == 2'd2) && (ram_raddr == waddr_reg);
        kd_reg  <= k_reg;
        ld_reg  <= l_reg;
        if (state_reg == sobm_pkg::ST_ROOT && mag_done)
        begin
            for (int c = 0; c < 3; c++)
            begin
                res_reg[c] <= mag_v[c];
            end
            res_fe_reg <= fe_reg;
        end
        if (state_reg == sobm_pkg::ST_DONE && load_out)
        begin
            ored_reg <= res_reg[0];
            ogrn_reg <= res_reg[1];
            oblu_reg <= res_reg[2];
            ofe_reg  <= res_fe_reg;
        end
    end

    assign results.valid     = ov_reg;
    assign results.out_red   = ored_reg;
    assign results.out_green = ogrn_reg;
    assign results.out_blue  = oblu_reg;
    assign results.frame_end = ofe_reg;
endmodule

[rtl/sobm_ring_ram.sv]
// Three-row pixel ring memory, one write and one registered read port.
`timescale 1ns / 1ps
module sobm_ring_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [sobm_pkg::ADDR_W-1:0] waddr,
    input  sobm_pkg::pixel_t            wdata,
    input  logic                        re,
    input  logic [sobm_pkg::ADDR_W-1:0] raddr,
    output sobm_pkg::pixel_t            rdata
);
    sobm_pkg::pixel_t mem [0:sobm_pkg::RAM_DEPTH-1];
    sobm_pkg::pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/sobm_mag.sv]
// Gradient magnitude for one channel: squares, bitwise root, rounding and cap.
`timescale 1ns / 1ps
module sobm_mag (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [sobm_pkg::GRAD_W-1:0] gx,
    input  logic signed [sobm_pkg::GRAD_W-1:0] gy,
    output logic                               done,
    output logic [7:0]                         mag
);
    logic [sobm_pkg::SUM_W-1:0]      s_reg;
    logic [sobm_pkg::SUM_W-1:0]      s_next;
    logic [7:0]                      n_reg;
    logic [7:0]                      n_next;
    logic [sobm_pkg::ROOT_CNT_W-1:0] cnt_reg;
    logic [sobm_pkg::ROOT_CNT_W-1:0] cnt_next;
    logic signed [2*sobm_pkg::GRAD_W-1:0] sqx;
    logic signed [2*sobm_pkg::GRAD_W-1:0] sqy;
    logic [7:0]                      bit_sel;
    logic [7:0]                      trial;
    logic [15:0]                     trial_sq;
    logic [16:0]                     round_lim;

    assign sqx      = gx * gx;
    assign sqy      = gy * gy;
    assign bit_sel  = 8'd1 << (cnt_reg - sobm_pkg::ROOT_CNT_W'(2));
    assign trial    = n_reg | bit_sel;
    assign trial_sq = 16'(trial) * 16'(trial);

    always_comb
    begin
        s_next   = s_reg;
        n_next   = n_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            s_next   = sobm_pkg::SUM_W'(sqx) + sobm_pkg::SUM_W'(sqy);
            n_next   = '0;
            cnt_next = sobm_pkg::ROOT_CNT_W'(sobm_pkg::ROOT_BITS + 1);
        end
        else if (cnt_reg > sobm_pkg::ROOT_CNT_W'(1))
        begin
            if (sobm_pkg::SUM_W'(trial_sq) <= s_reg)
            begin
                n_next = trial;
            end
            cnt_next = cnt_reg - sobm_pkg::ROOT_CNT_W'(1);
        end
        else if (cnt_reg == sobm_pkg::ROOT_CNT_W'(1))
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        n_reg <= n_next;
    end

    assign round_lim = 17'(16'(n_reg) * 16'(n_reg)) + 17'(n_reg);
    assign done      = (cnt_reg == sobm_pkg::ROOT_CNT_W'(1));

    always_comb
    begin
        if (s_reg > sobm_pkg::SUM_W'(sobm_pkg::CAP_SUM))
        begin
            mag = 8'hFF;
        end
        else if (s_reg > sobm_pkg::SUM_W'(round_lim))
        begin
            mag = n_reg + 8'd1;
        end
        else
        begin
            mag = n_reg;
        end
    end
endmodule
